### rtl/bpa_pkg.sv
// shared types and constants for the bitmap page allocator
`default_nettype none

package bpa_pkg;

    localparam int PAGE_W  = 40;
    localparam int COUNT_W = 6;
    localparam int USED_W  = 17;
    localparam int BITS_W  = 64;

    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_NOMEM  = 2'd1;
    localparam logic [1:0] STATUS_BADCNT = 2'd2;
    localparam logic [1:0] STATUS_RANGE  = 2'd3;

    localparam logic ACTION_ALLOC = 1'b0;
    localparam logic ACTION_FREE  = 1'b1;

    localparam logic CFG_BASE  = 1'b0;
    localparam logic CFG_WORDS = 1'b1;

    typedef struct packed {
        logic                action;
        logic [COUNT_W-1:0]  page_count;
        logic [PAGE_W-1:0]   page_number;
    } req_t;

    typedef struct packed {
        logic [1:0]          status;
        logic [PAGE_W-1:0]   first_page;
        logic [USED_W-1:0]   pages_in_use;
    } rsp_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_MARK,
        S_FREE_RD0,
        S_FREE_WR0,
        S_FREE_WR1,
        S_DONE
    } state_t;

    typedef struct packed {
        logic clr_step;
        logic load_req;
        logic decode;
        logic scan_start;
        logic scan_step;
        logic mark;
        logic rd_w0;
        logic wr_w0;
        logic wr_w1;
        logic free_done;
        logic res_badcnt;
        logic res_nomem;
        logic res_range;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic req_alloc;
        logic req_zero;
        logic out_range;
        logic hit;
        logic scan_done;
        logic span;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

### rtl/bpa_datapath.sv
// bitmap memory, scan and fit logic, counters and result register
`default_nettype none

module bpa_datapath #(
    parameter int WORDS = 1024
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire bpa_pkg::req_t     s_data,
    output bpa_pkg::rsp_t          m_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    input  wire logic              cfg_valid,
    input  wire logic              cfg_index,
    input  wire logic [39:0]       cfg_data,
    input  wire bpa_pkg::cmd_t     cmd,
    output bpa_pkg::sts_t          sts
);
    import bpa_pkg::*;

    localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int CW = AW + 1;

    // configuration
    logic [PAGE_W-1:0] base_reg;
    logic [10:0]       words_reg;

    // request
    logic              action_reg;
    logic [COUNT_W-1:0] cnt_reg;
    logic [PAGE_W-1:0] pnum_reg;

    // state
    logic [63:0]       mem [WORDS];
    logic [63:0]       rd_data_reg;
    logic [AW-1:0]     hint_reg;
    logic [USED_W-1:0] used_reg;
    logic [AW-1:0]     clr_addr_reg;

    // scan pipeline
    logic [AW-1:0]     addr_reg;
    logic [CW-1:0]     iss_reg;
    logic              dvalid_reg;
    logic [AW-1:0]     didx_reg;
    logic              dfirst_reg;
    logic [AW-1:0]     hit_idx_reg;
    logic [5:0]        hit_pos_reg;
    logic              hit_first_reg;
    logic [63:0]       new_word_reg;

    // free
    logic [AW+5:0]     off_reg;

    // result
    logic [1:0]        res_status_reg;
    logic [PAGE_W-1:0] res_first_reg;
    rsp_t              m_data_reg;
    logic              m_valid_reg;

    logic [CW-1:0]     n_words;
    logic [AW-1:0]     hint_eff;
    logic [40:0]       off_full;
    logic              out_range;
    logic [CW-1:0]     addr_inc;
    logic [AW-1:0]     addr_wrap;
    logic [63:0]       low_mask;
    logic [63:0]       run_map;
    logic              fit_hit;
    logic [5:0]        fit_pos;
    logic [AW-1:0]     w0;
    logic [AW-1:0]     w1;
    logic [127:0]      free_mask;
    logic              w1_ok;
    logic              we;
    logic [AW-1:0]     wa;
    logic [63:0]       wd;
    logic [AW-1:0]     rd_addr;
    logic [USED_W:0]   used_sum;

    // effective region size, clamped to 1..WORDS
    always_comb begin
        if (words_reg == 11'd0) begin
            n_words = CW'(1);
        end else if (32'(words_reg) > WORDS) begin
            n_words = CW'(WORDS);
        end else begin
            n_words = CW'(words_reg);
        end
    end

    assign hint_eff  = ({1'b0, hint_reg} >= n_words) ? '0 : hint_reg;
    assign off_full  = {1'b0, pnum_reg} - {1'b0, base_reg};
    assign out_range = off_full[40] || (off_full[39:0] >= 40'({n_words, 6'b0}));

    assign addr_inc  = {1'b0, addr_reg} + CW'(1);
    assign addr_wrap = (addr_inc == n_words) ? '0 : addr_inc[AW-1:0];

    assign low_mask  = (64'h1 << cnt_reg) - 64'h1;

    // runs of free bits by doubling: bit i of run_map set when cnt free bits start at i
    always_comb begin
        logic [63:0] p [6];
        logic [63:0] r;
        int unsigned sh;
        p[0] = ~rd_data_reg;
        for (int j = 1; j < 6; j++) begin
            p[j] = p[j-1] & (p[j-1] >> (1 << (j - 1)));
        end
        r  = '1;
        sh = 0;
        for (int j = 5; j >= 0; j--) begin
            if (cnt_reg[j]) begin
                r  = r & (p[j] >> sh);
                sh = sh + (1 << j);
            end
        end
        run_map = r;
    end

    always_comb begin
        fit_pos = '0;
        for (int i = 63; i >= 0; i--) begin
            if (run_map[i]) begin
                fit_pos = 6'(i);
            end
        end
    end

    assign fit_hit = |run_map;

    assign w0        = off_reg[AW+5:6];
    assign w1_ok     = ({1'b0, w0} + CW'(1)) < n_words;
    assign w1        = w0 + AW'(1);
    assign free_mask = {64'b0, low_mask} << off_reg[5:0];

    assign used_sum  = {1'b0, used_reg} + (USED_W+1)'(cnt_reg);

    // memory port selection
    always_comb begin
        we      = 1'b0;
        wa      = hit_idx_reg;
        wd      = new_word_reg;
        rd_addr = addr_reg;
        if (cmd.clr_step) begin
            we = 1'b1;
            wa = clr_addr_reg;
            wd = '0;
        end else if (cmd.mark) begin
            we = 1'b1;
        end else if (cmd.wr_w0) begin
            we = 1'b1;
            wa = w0;
            wd = rd_data_reg & ~free_mask[63:0];
        end else if (cmd.wr_w1) begin
            we = 1'b1;
            wa = w1;
            wd = rd_data_reg & ~free_mask[127:64];
        end
        if (cmd.rd_w0) begin
            rd_addr = w0;
        end else if (cmd.wr_w0) begin
            rd_addr = w1;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg  <= '0;
            words_reg <= 11'd1024;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_BASE:  base_reg  <= cfg_data;
                CFG_WORDS: words_reg <= cfg_data[10:0];
                default:   ;
            endcase
        end
    end

    // request and payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            action_reg <= s_data.action;
            cnt_reg    <= s_data.page_count;
            pnum_reg   <= s_data.page_number;
        end
        if (cmd.decode) begin
            off_reg <= off_full[AW+5:0];
        end
        if (cmd.scan_start) begin
            addr_reg <= hint_eff;
            iss_reg  <= '0;
        end else if (cmd.scan_step && (iss_reg != n_words)) begin
            addr_reg <= addr_wrap;
            iss_reg  <= iss_reg + CW'(1);
        end
        if (cmd.scan_step && (iss_reg != n_words)) begin
            didx_reg   <= addr_reg;
            dfirst_reg <= (iss_reg == '0);
        end
        if (cmd.scan_step && sts.hit) begin
            hit_idx_reg   <= didx_reg;
            hit_pos_reg   <= fit_pos;
            hit_first_reg <= dfirst_reg;
            new_word_reg  <= rd_data_reg | (low_mask << fit_pos);
        end
        if (cmd.out_load) begin
            m_data_reg.status       <= res_status_reg;
            m_data_reg.first_page   <= res_first_reg;
            m_data_reg.pages_in_use <= used_reg;
        end
        if (cmd.mark) begin
            res_status_reg <= STATUS_OK;
            res_first_reg  <= base_reg + PAGE_W'({hit_idx_reg, hit_pos_reg});
        end else if (cmd.free_done) begin
            res_status_reg <= STATUS_OK;
            res_first_reg  <= '0;
        end else if (cmd.res_badcnt) begin
            res_status_reg <= STATUS_BADCNT;
            res_first_reg  <= '0;
        end else if (cmd.res_nomem) begin
            res_status_reg <= STATUS_NOMEM;
            res_first_reg  <= '0;
        end else if (cmd.res_range) begin
            res_status_reg <= STATUS_RANGE;
            res_first_reg  <= '0;
        end
    end

    // control state of the datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hint_reg     <= '0;
            used_reg     <= '0;
            clr_addr_reg <= '0;
            dvalid_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cmd.clr_step) begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            if (cmd.scan_start) begin
                hint_reg   <= hint_eff;
                dvalid_reg <= 1'b0;
            end else if (cmd.scan_step) begin
                dvalid_reg <= (iss_reg != n_words);
            end
            if (cmd.mark) begin
                used_reg <= used_sum[USED_W] ? '1 : used_sum[USED_W-1:0];
                // hint word filled up: move on if a next word exists
                if (hit_first_reg && (new_word_reg == '1) &&
                    (({1'b0, hint_reg} + CW'(1)) < n_words)) begin
                    hint_reg <= hint_reg + AW'(1);
                end
            end else if (cmd.free_done) begin
                used_reg <= (used_reg > USED_W'(cnt_reg)) ?
                            used_reg - USED_W'(cnt_reg) : '0;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.clr_last  = (clr_addr_reg == AW'(WORDS - 1));
    assign sts.req_alloc = (action_reg == ACTION_ALLOC);
    assign sts.req_zero  = (cnt_reg == '0);
    assign sts.out_range = out_range;
    assign sts.hit       = dvalid_reg && fit_hit;
    assign sts.scan_done = !dvalid_reg && (iss_reg == n_words);
    assign sts.span      = (|free_mask[127:64]) && w1_ok;
    assign sts.out_free  = !m_valid_reg || m_ready;

    assign m_data  = m_data_reg;
    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

### rtl/bpa_ctrl.sv
// sequencer for clearing, allocate scan, free and result hand-off
`default_nettype none

module bpa_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire bpa_pkg::sts_t  sts,
    output bpa_pkg::cmd_t       cmd
);
    import bpa_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: begin
                if (sts.clr_last) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_valid) state_next = S_DECODE;
            end
            S_DECODE: begin
                if (sts.req_alloc) begin
                    state_next = sts.req_zero ? S_DONE : S_SCAN;
                end else begin
                    state_next = sts.out_range ? S_DONE : S_FREE_RD0;
                end
            end
            S_SCAN: begin
                if (sts.hit) begin
                    state_next = S_MARK;
                end else if (sts.scan_done) begin
                    state_next = S_DONE;
                end
            end
            S_MARK:     state_next = S_DONE;
            S_FREE_RD0: state_next = S_FREE_WR0;
            S_FREE_WR0: state_next = sts.span ? S_FREE_WR1 : S_DONE;
            S_FREE_WR1: state_next = S_DONE;
            S_DONE: begin
                if (sts.out_free) state_next = S_IDLE;
            end
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            S_CLEAR: cmd.clr_step = 1'b1;
            S_IDLE: begin
                s_ready      = 1'b1;
                cmd.load_req = s_valid;
            end
            S_DECODE: begin
                cmd.decode = 1'b1;
                if (sts.req_alloc) begin
                    cmd.res_badcnt = sts.req_zero;
                    cmd.scan_start = !sts.req_zero;
                end else begin
                    cmd.res_range = sts.out_range;
                end
            end
            S_SCAN: begin
                cmd.scan_step = 1'b1;
                cmd.res_nomem = !sts.hit && sts.scan_done;
            end
            S_MARK:     cmd.mark = 1'b1;
            S_FREE_RD0: cmd.rd_w0 = 1'b1;
            S_FREE_WR0: begin
                cmd.wr_w0     = 1'b1;
                cmd.free_done = !sts.span;
            end
            S_FREE_WR1: begin
                cmd.wr_w1     = 1'b1;
                cmd.free_done = 1'b1;
            end
            S_DONE:     cmd.out_load = sts.out_free;
            default:    ;
        endcase
    end

endmodule

`default_nettype wire

### rtl/bitmap_page_allocator.sv
// top level of the bitmap page allocator
//
// channel   direction  handshake            payload
// s_        in         s_valid / s_ready    s_data  (action, page_count, page_number)
// m_        out        m_valid / m_ready    m_data  (status, first_page, pages_in_use)
// cfg_      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// allocate decodes, scans from the hint word up to the fit (all region words when none fits),
// marks the run and hands off; free rewrites one bitmap word, or two when the run crosses a word
// the bitmap memory, read one word a cycle during the scan, sets the allocate time
// after reset a clearing pass zeroes every bitmap word; s_ready stays low meanwhile
// a result waiting in m_data does not block the next request from being taken
`default_nettype none

module bitmap_page_allocator #(
    parameter int WORDS = 1024
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire bpa_pkg::req_t   s_data,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output bpa_pkg::rsp_t        m_data,
    input  wire logic            cfg_valid,
    output logic                 cfg_ready,
    input  wire logic            cfg_index,
    input  wire logic [39:0]     cfg_data
);
    import bpa_pkg::*;

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    bpa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    bpa_datapath #(
        .WORDS (WORDS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .m_data    (m_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts)
    );

    // one request in flight at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request taken while another is in flight");

    // a fit found in the scan is marked in the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.scan_step && sts.hit) |=> cmd.mark)
        else $error("found run not marked");

    // only a successful allocate carries a page number
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.status != STATUS_OK)) |-> (m_data.first_page == '0))
        else $error("failed request returned a page");

endmodule

`default_nettype wire
